// ===== src/asa_pkg.sv =====
// Shared constants, codes and types for the arena slab allocator.
package asa_pkg;

   localparam int SlabsDef     = 16;
   localparam int ArenasDef    = 4;
   localparam int SlabBytesDef = 256;

   localparam int ActW   = 2;
   localparam int AidxW  = 3;
   localparam int ReqW   = 16;
   localparam int SidxW  = 4;
   localparam int StatW  = 3;
   localparam int OffW   = 9;
   localparam int RefW   = 16;

   typedef enum logic [ActW-1:0] {
      ACT_ALLOC   = 2'd0,
      ACT_ADD_REF = 2'd1,
      ACT_DROP    = 2'd2,
      ACT_RELEASE = 2'd3
   } action_type;

   typedef enum logic [StatW-1:0] {
      ST_OK        = 3'd0,
      ST_BAD_ARENA = 3'd1,
      ST_TOO_LARGE = 3'd2,
      ST_NO_SPACE  = 3'd3,
      ST_UNOWNED   = 3'd4,
      ST_UNDERFLOW = 3'd5,
      ST_REL_REFS  = 3'd6
   } status_type;

   // Result bundle from the sequencer to the output stage.
   typedef struct packed {
      logic [StatW-1:0] status;
      logic [SidxW-1:0] slab;
      logic [OffW-1:0]  offset;
      logic [RefW-1:0]  count;
      logic             released;
   } result_type;

endpackage

// ===== src/arena_slab_allocator_top.sv =====
// Top level of the arena slab allocator.
// Arena slab allocator: a pool of SLABS slabs shared by ARENAS arenas.
// Request channel (req_*): one operation per transfer, taken when
// req_valid is high and req_stall low. Actions: allocate, add reference,
// drop reference, release arena.
// Response channel (rsp_*): exactly one result per request, in order,
// held stable while rsp_stall is high.
// Table-only operations pass through decode and finish; allocate also
// walks the arena's chain and appends a free slab when none fits;
// release, and a drop that releases, also walk the chain, freeing each
// chained slab. The single chain-walk unit visits one link per cycle.
// One request is in flight at a time; req_stall stays high until the
// sequencer is idle and the output register can take the next result.
// Reset (synchronous, active high) empties all chains, gives head slab a
// to arena a, clears counts and fills the free stack.
// A stalled receiver holds the result; the block then stalls requests.
module arena_slab_allocator_top
   import asa_pkg::*;
#(
   parameter int SLABS      = SlabsDef,
   parameter int ARENAS     = ArenasDef,
   parameter int SLAB_BYTES = SlabBytesDef
)(
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_stall,
   input  logic [ActW-1:0]  req_action,
   input  logic [AidxW-1:0] req_arena_index,
   input  logic [ReqW-1:0]  req_request_bytes,
   input  logic [SidxW-1:0] req_slab_index,
   output logic             rsp_valid,
   input  logic             rsp_stall,
   output logic [StatW-1:0] rsp_status,
   output logic [SidxW-1:0] rsp_granted_slab,
   output logic [OffW-1:0]  rsp_granted_offset,
   output logic [RefW-1:0]  rsp_reference_count,
   output logic             rsp_released
);

   logic       seq_idle, seq_done, out_busy, start;
   result_type seq_res, out_res;

   // Only start when the previous result has left or is leaving.
   assign req_stall = !seq_idle || out_busy || seq_done;
   assign start     = req_valid && !req_stall;

   asa_seq #(.SLABS(SLABS), .ARENAS(ARENAS), .SLAB_BYTES(SLAB_BYTES)) u_seq (
      .clock, .reset, .start,
      .action(req_action), .arena_index(req_arena_index),
      .request_bytes(req_request_bytes), .slab_index(req_slab_index),
      .idle(seq_idle), .done(seq_done), .result(seq_res)
   );

   asa_out_reg u_out (
      .clock, .reset, .load(seq_done), .load_data(seq_res),
      .busy(out_busy), .rsp_valid, .rsp_stall, .rsp_data(out_res)
   );

   assign rsp_status          = out_res.status;
   assign rsp_granted_slab    = out_res.slab;
   assign rsp_granted_offset  = out_res.offset;
   assign rsp_reference_count = out_res.count;
   assign rsp_released        = out_res.released;

   // A request is never taken while a stalled result waits.
   a_no_accept_when_busy: assert property (@(posedge clock) disable iff (reset)
      out_busy |-> !start) else $error("request taken while result stalled");

   // An accepted request blocks the next one.
   a_one_in_flight: assert property (@(posedge clock) disable iff (reset)
      start |=> req_stall) else $error("second request taken in flight");

   // A release result reports a zero count.
   a_release_zero: assert property (@(posedge clock) disable iff (reset)
      seq_done && seq_res.released |-> seq_res.count == '0)
      else $error("released arena with nonzero count");

endmodule

// ===== src/asa_out_reg.sv =====
// Output register holding one result until the receiver takes it.
module asa_out_reg
   import asa_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  logic       load,
   input  result_type load_data,
   output logic       busy,
   output logic       rsp_valid,
   input  logic       rsp_stall,
   output result_type rsp_data
);

   logic       valid_ff, valid_in;
   result_type data_ff, data_in;

   // Hold until the transfer completes, then accept a new result.
   always_comb begin
      valid_in = valid_ff;
      data_in  = data_ff;
      if (valid_ff && !rsp_stall) begin
         valid_in = 1'b0;
      end
      if (load) begin
         valid_in = 1'b1;
         data_in  = load_data;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
      data_ff <= data_in;
   end

   assign busy      = valid_ff && rsp_stall;
   assign rsp_valid = valid_ff;
   assign rsp_data  = data_ff;

endmodule

// ===== src/asa_seq.sv =====
// Sequencer with one shared chain-walk unit over the slab tables.
module asa_seq
   import asa_pkg::*;
#(
   parameter int SLABS      = SlabsDef,
   parameter int ARENAS     = ArenasDef,
   parameter int SLAB_BYTES = SlabBytesDef
)(
   input  logic             clock,
   input  logic             reset,
   input  logic             start,
   input  logic [ActW-1:0]  action,
   input  logic [AidxW-1:0] arena_index,
   input  logic [ReqW-1:0]  request_bytes,
   input  logic [SidxW-1:0] slab_index,
   output logic             idle,
   output logic             done,
   output result_type       result
);

   localparam int LiveArenas = (ARENAS < SLABS) ? ARENAS : SLABS;
   localparam int SW  = (SLABS > 1) ? $clog2(SLABS) : 1;
   localparam int CW  = $clog2(SLABS + 1);
   localparam int AW  = (ARENAS > 1) ? $clog2(ARENAS) : 1;
   localparam int FW  = $clog2(SLAB_BYTES + 1);
   localparam logic [RefW-1:0] RefMax = '1;

   typedef enum logic [2:0] {
      S_IDLE, S_DECODE, S_WALK, S_APPEND, S_REL_WALK, S_FINISH
   } state_type;

   state_type state_ff;
   logic [SW-1:0]   link_ff   [SLABS];
   logic [SLABS-1:0] link_ok_ff;
   logic [FW-1:0]   fill_ff   [SLABS];
   logic [AW-1:0]   owner_ff  [SLABS];
   logic [SLABS-1:0] owned_ff;
   logic [RefW-1:0] refs_ff   [ARENAS];
   logic [SW-1:0]   stack_ff  [SLABS];
   logic [CW-1:0]   free_cnt_ff;

   logic [ActW-1:0]  act_ff;
   logic [AidxW-1:0] aidx_ff;
   logic [ReqW-1:0]  size_ff;
   logic [SidxW-1:0] sidx_ff;
   logic [AW-1:0]    arena_ff;
   logic [SW-1:0]    cur_ff;
   logic             more_ff;
   logic [CW-1:0]    steps_ff;
   result_type       res_ff;
   logic             done_ff;

   // Shared unit: room check on the current slab.
   logic [FW:0] room;
   logic        fits;
   assign room = (FW+1)'(SLAB_BYTES) - {1'b0, fill_ff[cur_ff]};
   assign fits = {{(ReqW > FW+1 ? ReqW-FW-1 : 0){1'b0}}, room} >= size_ff;

   logic             sidx_ok;
   logic [SW-1:0]    si;
   assign si      = SW'(sidx_ff);
   assign sidx_ok = (32'(sidx_ff) < SLABS) && owned_ff[si] &&
                    (32'(owner_ff[si]) < LiveArenas);

   logic [SW-1:0] pop_slab;
   assign pop_slab = stack_ff[SW'(free_cnt_ff - CW'(1))];

   always_ff @(posedge clock) begin
      if (reset) begin
         done_ff     <= 1'b0;
         state_ff    <= S_IDLE;
         free_cnt_ff <= CW'(SLABS - LiveArenas);
         link_ok_ff  <= '0;
         for (int i = 0; i < SLABS; i++) begin
            link_ff[i]  <= '0;
            fill_ff[i]  <= '0;
            owner_ff[i] <= (i < LiveArenas) ? AW'(i) : '0;
            owned_ff[i] <= (i < LiveArenas);
            stack_ff[i] <= (i < SLABS - LiveArenas) ? SW'(i + LiveArenas) : '0;
         end
         for (int i = 0; i < ARENAS; i++) begin
            refs_ff[i] <= '0;
         end
      end else begin
         done_ff <= (state_ff == S_FINISH);
         unique case (state_ff)
            S_IDLE: begin
               if (start) begin
                  act_ff   <= action;
                  aidx_ff  <= arena_index;
                  size_ff  <= request_bytes;
                  sidx_ff  <= slab_index;
                  res_ff   <= '0;
                  state_ff <= S_DECODE;
               end
            end
            S_DECODE: begin
               steps_ff <= '0;
               if (act_ff == ACT_ALLOC || act_ff == ACT_RELEASE) begin
                  if (32'(aidx_ff) >= LiveArenas) begin
                     res_ff.status <= ST_BAD_ARENA;
                     state_ff      <= S_FINISH;
                  end else if (act_ff == ACT_RELEASE) begin
                     if (refs_ff[AW'(aidx_ff)] != '0) res_ff.status <= ST_REL_REFS;
                     res_ff.released <= 1'b1;
                     arena_ff <= AW'(aidx_ff);
                     cur_ff   <= link_ff[SW'(aidx_ff)];
                     more_ff  <= link_ok_ff[SW'(aidx_ff)];
                     link_ok_ff[SW'(aidx_ff)] <= 1'b0;
                     link_ff[SW'(aidx_ff)]    <= '0;
                     fill_ff[SW'(aidx_ff)]    <= '0;
                     refs_ff[AW'(aidx_ff)]    <= '0;
                     state_ff <= S_REL_WALK;
                  end else if (32'(size_ff) > SLAB_BYTES) begin
                     res_ff.status <= ST_TOO_LARGE;
                     res_ff.count  <= refs_ff[AW'(aidx_ff)];
                     state_ff      <= S_FINISH;
                  end else begin
                     arena_ff <= AW'(aidx_ff);
                     cur_ff   <= SW'(aidx_ff);
                     state_ff <= S_WALK;
                  end
               end else begin
                  if (!sidx_ok) begin
                     res_ff.status <= ST_UNOWNED;
                     state_ff      <= S_FINISH;
                  end else begin
                     arena_ff <= owner_ff[si];
                     if (act_ff == ACT_ADD_REF) begin
                        if (refs_ff[owner_ff[si]] != RefMax) begin
                           refs_ff[owner_ff[si]] <= refs_ff[owner_ff[si]] + 1'b1;
                           res_ff.count <= refs_ff[owner_ff[si]] + 1'b1;
                        end else begin
                           res_ff.count <= RefMax;
                        end
                        state_ff <= S_FINISH;
                     end else if (refs_ff[owner_ff[si]] > RefW'(1)) begin
                        refs_ff[owner_ff[si]] <= refs_ff[owner_ff[si]] - 1'b1;
                        res_ff.count <= refs_ff[owner_ff[si]] - 1'b1;
                        state_ff <= S_FINISH;
                     end else begin
                        // Count reaches or is already zero: release the owning arena.
                        if (refs_ff[owner_ff[si]] == '0) res_ff.status <= ST_UNDERFLOW;
                        res_ff.released <= 1'b1;
                        cur_ff  <= link_ff[SW'(owner_ff[si])];
                        more_ff <= link_ok_ff[SW'(owner_ff[si])];
                        link_ok_ff[SW'(owner_ff[si])] <= 1'b0;
                        link_ff[SW'(owner_ff[si])]    <= '0;
                        fill_ff[SW'(owner_ff[si])]    <= '0;
                        refs_ff[owner_ff[si]]         <= '0;
                        state_ff <= S_REL_WALK;
                     end
                  end
               end
            end
            S_WALK: begin
               // One chain link per cycle.
               if (fits) begin
                  res_ff.slab   <= SidxW'(cur_ff);
                  res_ff.offset <= OffW'(fill_ff[cur_ff]);
                  fill_ff[cur_ff] <= FW'(fill_ff[cur_ff] + size_ff[FW-1:0]);
                  if (refs_ff[arena_ff] != RefMax) begin
                     refs_ff[arena_ff] <= refs_ff[arena_ff] + 1'b1;
                     res_ff.count <= refs_ff[arena_ff] + 1'b1;
                  end else begin
                     res_ff.count <= RefMax;
                  end
                  state_ff <= S_FINISH;
               end else if (!link_ok_ff[cur_ff] || steps_ff == CW'(SLABS - 1)) begin
                  state_ff <= S_APPEND;
               end else begin
                  cur_ff   <= link_ff[cur_ff];
                  steps_ff <= steps_ff + 1'b1;
               end
            end
            S_APPEND: begin
               if (free_cnt_ff == '0) begin
                  res_ff.status <= ST_NO_SPACE;
                  res_ff.count  <= refs_ff[arena_ff];
                  state_ff      <= S_FINISH;
               end else begin
                  free_cnt_ff <= free_cnt_ff - 1'b1;
                  link_ff[cur_ff]      <= pop_slab;
                  link_ok_ff[cur_ff]   <= 1'b1;
                  link_ok_ff[pop_slab] <= 1'b0;
                  link_ff[pop_slab]    <= '0;
                  owned_ff[pop_slab]   <= 1'b1;
                  owner_ff[pop_slab]   <= arena_ff;
                  cur_ff   <= pop_slab;
                  steps_ff <= CW'(SLABS - 1);
                  state_ff <= S_WALK;
               end
            end
            S_REL_WALK: begin
               // Free one chained slab per cycle, in chain order.
               if (!more_ff || steps_ff == CW'(SLABS)) begin
                  state_ff <= S_FINISH;
               end else begin
                  more_ff  <= link_ok_ff[cur_ff];
                  cur_ff   <= link_ff[cur_ff];
                  link_ok_ff[cur_ff] <= 1'b0;
                  link_ff[cur_ff]    <= '0;
                  fill_ff[cur_ff]    <= '0;
                  owned_ff[cur_ff]   <= 1'b0;
                  owner_ff[cur_ff]   <= '0;
                  if (free_cnt_ff < CW'(SLABS)) begin
                     stack_ff[SW'(free_cnt_ff)] <= cur_ff;
                     free_cnt_ff <= free_cnt_ff + 1'b1;
                  end
                  steps_ff <= steps_ff + 1'b1;
               end
            end
            S_FINISH: begin
               state_ff <= S_IDLE;
            end
            default: state_ff <= S_IDLE;
         endcase
      end
   end

   assign idle   = (state_ff == S_IDLE);
   assign done   = done_ff;
   assign result = res_ff;

endmodule

// ===== bench/asa_checker.sv =====
// Checker for the arena slab allocator: predicts every result and compares.
module asa_checker
   import asa_pkg::*;
(
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   input  logic             req_stall,
   input  logic [ActW-1:0]  req_action,
   input  logic [AidxW-1:0] req_arena_index,
   input  logic [ReqW-1:0]  req_request_bytes,
   input  logic [SidxW-1:0] req_slab_index,
   input  logic             rsp_valid,
   input  logic             rsp_stall,
   input  logic [StatW-1:0] rsp_status,
   input  logic [SidxW-1:0] rsp_granted_slab,
   input  logic [OffW-1:0]  rsp_granted_offset,
   input  logic [RefW-1:0]  rsp_reference_count,
   input  logic             rsp_released,
   output int               fail_count,
   output int               pending_count
);

   localparam int SLABS      = SlabsDef;
   localparam int ARENAS     = ArenasDef;
   localparam int SLAB_BYTES = SlabBytesDef;
   localparam int LIVE       = (ARENAS < SLABS) ? ARENAS : SLABS;
   localparam int REF_MAX    = 65535;

   // Shadow of the allocator state
   int  link_to [SLABS];
   bit  link_on [SLABS];
   int  fill    [SLABS];
   int  owner   [SLABS];
   bit  is_owned[SLABS];
   int  refs    [ARENAS];
   int  free_stk[SLABS];
   int  free_top;

   result_type expected_results[$];

   function automatic void shadow_reset();
      free_top = 0;
      for (int i = 0; i < SLABS; i++) begin
         link_to[i] = 0; link_on[i] = 0; fill[i] = 0;
         owner[i] = (i < LIVE) ? i : 0;
         is_owned[i] = (i < LIVE);
         free_stk[i] = 0;
      end
      for (int i = 0; i < ARENAS; i++) refs[i] = 0;
      for (int i = LIVE; i < SLABS; i++) begin
         free_stk[free_top] = i;
         free_top++;
      end
   endfunction

   // Free the chain of arena a in order, empty its head
   function automatic void free_arena(int a);
      int  cur;
      int  nxt;
      bit  more;
      more = link_on[a];
      nxt = link_to[a];
      link_on[a] = 0; link_to[a] = 0; fill[a] = 0; refs[a] = 0;
      for (int k = 0; more && k < SLABS; k++) begin
         cur = nxt % SLABS;
         more = link_on[cur];
         nxt = link_to[cur];
         link_on[cur] = 0; link_to[cur] = 0; fill[cur] = 0;
         is_owned[cur] = 0; owner[cur] = 0;
         if (free_top < SLABS) begin
            free_stk[free_top] = cur;
            free_top++;
         end
      end
   endfunction

   function automatic result_type predict_result(action_type act, int a, int size, int si);
      result_type r;
      int  cur;
      int  s;
      int  o;
      bit  done;
      r = '0;
      r.status = ST_OK;
      if (act == ACT_ALLOC || act == ACT_RELEASE) begin
         if (a >= LIVE) begin
            r.status = ST_BAD_ARENA;
         end else if (act == ACT_RELEASE) begin
            if (refs[a] > 0) r.status = ST_REL_REFS;
            free_arena(a);
            r.released = 1'b1;
         end else if (size > SLAB_BYTES) begin
            r.status = ST_TOO_LARGE;
            r.count = RefW'(refs[a]);
         end else begin
            cur = a;
            done = 0;
            for (int k = 0; k < SLABS; k++) begin
               if (SLAB_BYTES - fill[cur] >= size) begin
                  done = 1;
                  break;
               end
               if (!link_on[cur]) break;
               cur = link_to[cur] % SLABS;
            end
            if (!done && free_top > 0) begin
               free_top--;
               s = free_stk[free_top] % SLABS;
               link_to[cur] = s; link_on[cur] = 1;
               link_on[s] = 0; link_to[s] = 0;
               is_owned[s] = 1; owner[s] = a;
               cur = s;
               if (SLAB_BYTES - fill[cur] >= size) done = 1;
            end
            if (done) begin
               r.slab = SidxW'(cur);
               r.offset = OffW'(fill[cur]);
               fill[cur] += size;
               if (refs[a] < REF_MAX) refs[a]++;
            end else begin
               r.status = ST_NO_SPACE;
            end
            r.count = RefW'(refs[a]);
         end
      end else begin
         if (si >= SLABS || !is_owned[si] || owner[si] >= LIVE) begin
            r.status = ST_UNOWNED;
         end else begin
            o = owner[si];
            if (act == ACT_ADD_REF) begin
               if (refs[o] < REF_MAX) refs[o]++;
            end else begin
               if (refs[o] == 0) r.status = ST_UNDERFLOW;
               else refs[o]--;
               if (refs[o] == 0) begin
                  free_arena(o);
                  r.released = 1'b1;
               end
            end
            r.count = RefW'(refs[o]);
         end
      end
      return r;
   endfunction

   task automatic report_mismatch(string what, int got, int want);
      $display("MISMATCH %s: got %0d expected %0d at %0t", what, got, want, $time);
      fail_count++;
   endtask

   // Watch both channels at each rising edge
   always @(posedge clock) begin
      result_type want;
      if (reset) begin
         shadow_reset();
         expected_results.delete();
      end else begin
         if (rsp_valid && !rsp_stall) begin
            if (expected_results.size() == 0) begin
               report_mismatch("unexpected result", 1, 0);
            end else begin
               want = expected_results.pop_front();
               if (rsp_status !== want.status)
                  report_mismatch("status", int'(rsp_status), int'(want.status));
               if (rsp_granted_slab !== want.slab)
                  report_mismatch("granted_slab", int'(rsp_granted_slab),
                                  int'(want.slab));
               if (rsp_granted_offset !== want.offset)
                  report_mismatch("granted_offset", int'(rsp_granted_offset),
                                  int'(want.offset));
               if (rsp_reference_count !== want.count)
                  report_mismatch("reference_count", int'(rsp_reference_count),
                                  int'(want.count));
               if (rsp_released !== want.released)
                  report_mismatch("released", int'(rsp_released), int'(want.released));
            end
         end
         if (req_valid && !req_stall)
            expected_results.push_back(predict_result(action_type'(req_action),
               int'(req_arena_index), int'(req_request_bytes), int'(req_slab_index)));
      end
      pending_count = expected_results.size();
   end

endmodule

// ===== bench/tb_top.sv =====
// Testbench top: drives the allocator and gives the verdict.
module tb_top;
   import asa_pkg::*;

   localparam int LIMIT = 400000;

   logic             clock = 0;
   logic             reset = 1;
   logic             req_valid = 0;
   logic             req_stall;
   logic [ActW-1:0]  req_action = ACT_ALLOC;
   logic [AidxW-1:0] req_arena_index = 0;
   logic [ReqW-1:0]  req_request_bytes = 0;
   logic [SidxW-1:0] req_slab_index = 0;
   logic             rsp_valid;
   logic             rsp_stall = 0;
   logic [StatW-1:0] rsp_status;
   logic [SidxW-1:0] rsp_granted_slab;
   logic [OffW-1:0]  rsp_granted_offset;
   logic [RefW-1:0]  rsp_reference_count;
   logic             rsp_released;
   logic             in_taken = 0;
   int               fail_count;
   int               pending_count;
   int               cycles = 0;
   bit               calm = 0;

   always #5 clock = ~clock;

   arena_slab_allocator_top u_dut (.*);
   asa_checker u_chk (.*);

   // Run guard
   always @(posedge clock) begin
      cycles++;
      if (cycles > LIMIT) begin
         $display("arena_slab_allocator_top test failed");
         $finish;
      end
   end

   // Marks the cycle after a request transfer
   always @(posedge clock) begin
      in_taken <= !reset && req_valid && !req_stall;
   end

   // Receiver stalls in bursts, none once calm
   initial begin
      int n;
      forever begin
         @(negedge clock);
         if (!calm && $urandom_range(0, 5) == 0) begin
            n = $urandom_range(1, 9);
            rsp_stall <= 1;
            repeat (n) @(negedge clock);
            rsp_stall <= 0;
         end
      end
   end

   // One transfer; idles before it at random, returns on the falling edge
   // after the transfer
   task automatic send_op(action_type act, int a, int size, int si);
      if (!calm && $urandom_range(0, 5) == 0) begin
         req_valid <= 0;
         repeat ($urandom_range(1, 9)) @(negedge clock);
      end
      req_valid <= 1;
      req_action <= act;
      req_arena_index <= AidxW'(a);
      req_request_bytes <= ReqW'(size);
      req_slab_index <= SidxW'(si);
      do @(negedge clock); while (!in_taken);
   endtask

   // Mostly legal-looking work on a few arenas, some noise
   task automatic random_op();
      int r;
      r = $urandom_range(0, 99);
      if (r < 50)
         send_op(ACT_ALLOC, $urandom_range(0, 4),
                 ($urandom_range(0, 9) == 0) ? $urandom_range(0, 65535)
                                             : $urandom_range(0, 200), 0);
      else if (r < 70)
         send_op(ACT_ADD_REF, 0, $urandom_range(0, 65535), $urandom_range(0, 15));
      else if (r < 92)
         send_op(ACT_DROP, $urandom_range(0, 7), 0, $urandom_range(0, 15));
      else
         send_op(ACT_RELEASE, $urandom_range(0, 7), 0, $urandom_range(0, 15));
   endtask

   initial begin
      repeat (8) @(posedge clock);
      @(negedge clock);
      reset <= 0;
      // Directed: field extremes, each action, each error case
      send_op(ACT_ALLOC, 7, 16, 0);          // bad arena
      send_op(ACT_ALLOC, 0, 257, 0);         // too large
      send_op(ACT_ALLOC, 0, 65535, 15);      // too large, max field
      send_op(ACT_ALLOC, 0, 0, 0);           // zero-byte request
      send_op(ACT_ALLOC, 0, 256, 0);         // fill head exactly
      send_op(ACT_ALLOC, 0, 256, 0);         // chain a new slab
      send_op(ACT_ADD_REF, 0, 0, 15);        // top slab now owned by arena 0
      send_op(ACT_ADD_REF, 0, 0, 14);        // unowned slab
      send_op(ACT_DROP, 0, 0, 3);            // drop on arena 3 at zero
      send_op(ACT_RELEASE, 0, 0, 0);         // release with references
      send_op(ACT_RELEASE, 1, 0, 0);         // release idle arena
      send_op(ACT_RELEASE, 5, 0, 0);         // bad arena on release
      for (int i = 0; i < 14; i++) send_op(ACT_ALLOC, 2, 256, 0); // exhaust pool
      send_op(ACT_ALLOC, 1, 1, 0);
      send_op(ACT_ALLOC, 1, 256, 0);         // no space
      send_op(ACT_DROP, 0, 0, 2);
      for (int i = 0; i < 1500; i++) begin
         if (i == 1350) calm = 1;
         if (i % 300 == 299) begin
            // Periodic release to recycle slabs
            send_op(ACT_RELEASE, $urandom_range(0, 3), 0, 0);
         end
         random_op();
      end
      req_valid <= 0;
      while (pending_count != 0) @(posedge clock);
      repeat (40) @(posedge clock);
      if (fail_count == 0)
         $display("arena_slab_allocator_top test passed");
      else
         $display("arena_slab_allocator_top test failed");
      $finish;
   end

endmodule

// ===== files.f =====
src/asa_pkg.sv
src/asa_out_reg.sv
src/asa_seq.sv
src/arena_slab_allocator_top.sv
bench/asa_checker.sv
bench/tb_top.sv
